/* rtl/bbre_pkg.sv */
package bbre_pkg;

    localparam int BM_BYTES = 4096;
    localparam int BM_AW    = $clog2(BM_BYTES);
    localparam int BM_CAP   = BM_BYTES * 8;

    localparam logic [2:0] MODE_SET    = 3'd0;
    localparam logic [2:0] MODE_CLEAR  = 3'd1;
    localparam logic [2:0] MODE_INVERT = 3'd2;
    localparam logic [2:0] MODE_FIND   = 3'd3;
    localparam logic [2:0] MODE_COUNT  = 3'd4;
    localparam logic [2:0] MODE_BYTE   = 3'd5;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd;
        logic ev;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic imm;
        logic again;
        logic done;
    } t_sts;

endpackage

/* rtl/bbre_ctrl.sv */
module bbre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  bbre_pkg::t_sts i_sts,
    output bbre_pkg::t_cmd o_cmd
);
    import bbre_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       out_ok;

    assign out_ok = !r_ovalid || !i_out_stall;

    always_comb begin
        o_cmd.clr_step = (r_state == S_CLR);
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd       = (r_state == S_RD);
        o_cmd.ev       = (r_state == S_EV);
        o_cmd.out_load = (r_state == S_FIN) && out_ok;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE: if (i_in_valid) n_state = i_sts.imm ? S_FIN : S_RD;
            S_RD:   n_state = S_EV;
            S_EV: begin
                if (i_sts.done) n_state = S_FIN;
                else if (!i_sts.again) n_state = S_RD;
            end
            S_FIN:  if (out_ok) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (!i_out_stall) n_ovalid = 1'b0;
        if (o_cmd.out_load) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_ovalid || !i_out_stall))
        else $error("result overwritten");
    a_no_load_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_cmd.load)
        else $error("item taken during clearing");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("result lost");
    a_ev_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> o_cmd.ev)
        else $error("read not evaluated");

endmodule

/* rtl/bbre_dp.sv */
module bbre_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbre_pkg::t_cmd i_cmd,
    output bbre_pkg::t_sts o_sts,
    input  logic           i_cfg_valid,
    input  logic [15:0]    i_cfg_data,
    input  logic [2:0]     i_mode,
    input  logic [14:0]    i_bit_offset,
    input  logic [15:0]    i_run_length,
    input  logic [11:0]    i_byte_index,
    input  logic [7:0]     i_write_data,
    input  logic           i_write_enable,
    output logic           o_status,
    output logic [11:0]    o_first_byte,
    output logic [12:0]    o_bytes_touched,
    output logic [14:0]    o_found_offset,
    output logic [15:0]    o_found_length,
    output logic [15:0]    o_next_start,
    output logic [15:0]    o_set_count,
    output logic [7:0]     o_read_data
);
    import bbre_pkg::*;

    function automatic logic [2:0] first_one(input logic [7:0] v);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) k = 3'(i);
        end
        return k;
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

    logic [7:0]       r_mem [BM_BYTES];
    logic [15:0]      r_bits;
    logic [BM_AW-1:0] r_clr;

    logic [2:0]       r_mode;
    logic [7:0]       r_wdata;
    logic             r_wen;
    logic [15:0]      r_vb, n_vb;
    logic [BM_AW-1:0] r_addr, n_addr;
    logic [BM_AW-1:0] r_last, n_last;
    logic [2:0]       r_lo, n_lo;
    logic [2:0]       r_hib, n_hib;
    logic             r_phase, n_phase;
    logic [7:0]       r_rd;

    logic             r_status, n_status;
    logic [11:0]      r_first, n_first;
    logic [12:0]      r_touched, n_touched;
    logic [14:0]      r_foff, n_foff;
    logic [15:0]      r_flen, n_flen;
    logic [15:0]      r_nxt, n_nxt;
    logic [15:0]      r_cnt, n_cnt;
    logic [7:0]       r_rdata, n_rdata;

    logic [15:0]      v_bits;
    logic [16:0]      end17, endm1;
    logic             err;
    logic [16:0]      rem;
    logic             last_byte;
    logic [7:0]       vm, mask, cand, newv;
    logic [2:0]       hi_eff, k;
    logic [15:0]      pos16;
    logic             again, done;
    logic             we;
    logic [BM_AW-1:0] wa;
    logic [7:0]       wd;

    assign v_bits = (r_bits > 16'(BM_CAP)) ? 16'(BM_CAP) : r_bits;
    assign end17  = {2'b0, i_bit_offset} + {1'b0, i_run_length};
    assign endm1  = end17 - 17'd1;
    assign err    = (i_run_length != 16'd0) &&
                    (({1'b0, i_bit_offset} >= v_bits) || (i_run_length > v_bits) ||
                     (end17 > {1'b0, v_bits}));

    assign rem       = {1'b0, r_vb} - {2'b0, r_addr, 3'b000};
    assign last_byte = (rem <= 17'd8);
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            vm[i] = (rem > 17'(i));
        end
    end

    assign hi_eff = (r_addr == r_last) ? r_hib : 3'd7;
    assign mask   = (8'hFF << r_lo) & (8'hFF >> (3'd7 - hi_eff));
    always_comb begin
        unique case (r_mode)
            MODE_SET:    newv = r_rd | mask;
            MODE_CLEAR:  newv = r_rd & ~mask;
            default:     newv = r_rd ^ mask;
        endcase
    end

    assign cand  = (r_phase ? ~r_rd : r_rd) & vm & (8'hFF << r_lo);
    assign k     = first_one(cand);
    assign pos16 = {1'b0, r_addr, k};

    always_comb begin
        n_vb = r_vb; n_addr = r_addr; n_last = r_last; n_lo = r_lo; n_hib = r_hib;
        n_phase = r_phase; n_status = r_status; n_first = r_first;
        n_touched = r_touched; n_foff = r_foff; n_flen = r_flen; n_nxt = r_nxt;
        n_cnt = r_cnt; n_rdata = r_rdata;
        again = 1'b0;
        done  = 1'b0;
        if (i_cmd.load) begin
            n_vb      = v_bits;
            n_phase   = 1'b0;
            n_lo      = i_bit_offset[2:0];
            n_hib     = endm1[2:0];
            n_last    = endm1[14:3];
            n_status  = (i_mode <= MODE_INVERT) && err;
            n_first   = ((i_mode <= MODE_INVERT) && !err && (i_run_length != 16'd0)) ?
                        i_bit_offset[14:3] : 12'd0;
            n_touched = 13'd0;
            n_foff    = 15'd0;
            n_flen    = 16'd0;
            n_nxt     = (i_mode == MODE_FIND) ? v_bits : 16'd0;
            n_cnt     = 16'd0;
            n_rdata   = 8'd0;
            priority case (1'b1)
                (i_mode == MODE_COUNT): n_addr = '0;
                (i_mode == MODE_BYTE):  n_addr = i_byte_index;
                default:                n_addr = i_bit_offset[14:3];
            endcase
        end else if (i_cmd.ev) begin
            if (r_mode <= MODE_INVERT) begin
                n_touched = r_touched + 13'd1;
                n_lo      = 3'd0;
                n_addr    = r_addr + 1'b1;
                done      = (r_addr == r_last);
            end else if (r_mode == MODE_FIND) begin
                if (cand != 8'd0) begin
                    if (!r_phase) begin
                        n_foff  = pos16[14:0];
                        n_phase = 1'b1;
                        n_lo    = k;
                        again   = 1'b1;
                    end else begin
                        n_nxt  = pos16;
                        n_flen = pos16 - {1'b0, r_foff};
                        done   = 1'b1;
                    end
                end else if (last_byte) begin
                    done   = 1'b1;
                    n_nxt  = r_vb;
                    n_flen = r_phase ? (r_vb - {1'b0, r_foff}) : 16'd0;
                end else begin
                    n_addr = r_addr + 1'b1;
                    n_lo   = 3'd0;
                end
            end else if (r_mode == MODE_COUNT) begin
                n_cnt  = r_cnt + 16'(pop8(r_rd & vm));
                n_addr = r_addr + 1'b1;
                done   = last_byte;
            end else begin
                n_rdata = r_wen ? r_wdata : r_rd;
                done    = 1'b1;
            end
        end
    end

    assign o_sts.clr_done = (r_clr == BM_AW'(BM_BYTES - 1));
    assign o_sts.imm      = ((i_mode <= MODE_INVERT) && ((i_run_length == 16'd0) || err)) ||
                            ((i_mode == MODE_FIND) && ({1'b0, i_bit_offset} >= v_bits)) ||
                            ((i_mode == MODE_COUNT) && (v_bits == 16'd0)) ||
                            (i_mode > MODE_BYTE);
    assign o_sts.again    = again;
    assign o_sts.done     = done;

    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = newv;
        if (i_cmd.clr_step) begin
            we = 1'b1;
            wa = r_clr;
            wd = 8'd0;
        end else if (i_cmd.rd && (r_mode == MODE_BYTE) && r_wen) begin
            we = 1'b1;
            wd = r_wdata;
        end else if (i_cmd.ev && (r_mode <= MODE_INVERT)) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (i_cmd.rd) r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 16'(BM_CAP);
            r_clr  <= '0;
        end else begin
            if (i_cfg_valid) r_bits <= i_cfg_data;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_wdata <= i_write_data;
            r_wen   <= i_write_enable;
        end
        r_vb <= n_vb; r_addr <= n_addr; r_last <= n_last; r_lo <= n_lo; r_hib <= n_hib;
        r_phase <= n_phase; r_status <= n_status; r_first <= n_first;
        r_touched <= n_touched; r_foff <= n_foff; r_flen <= n_flen; r_nxt <= n_nxt;
        r_cnt <= n_cnt; r_rdata <= n_rdata;
        if (i_cmd.out_load) begin
            o_status        <= r_status;
            o_first_byte    <= r_first;
            o_bytes_touched <= r_touched;
            o_found_offset  <= r_foff;
            o_found_length  <= r_flen;
            o_next_start    <= r_nxt;
            o_set_count     <= r_cnt;
            o_read_data     <= r_rdata;
        end
    end

endmodule

/* rtl/bitmap_bit_run_engine.sv */
// channel  direction  handshake               payload
// in       input      i_in_valid/o_in_stall   mode, bit_offset, run_length, byte_index, ...
// out      output     o_out_valid/i_out_stall status, first_byte, ..., read_data
// cfg      input      i_cfg_valid/o_cfg_ready bitmap_bits
//
// after reset a clearing pass zeroes all 4096 bytes of the store before any item is taken
// run, find and count items walk the store byte by byte, one store read then one
// evaluate per byte, and a find that meets a set bit evaluates that byte once more;
// a byte access does one read and one evaluate; an item with nothing to walk goes
// straight to its result; the result waits in an output register, so a stalled result
// does not hold back the next item until that item's own result is ready
module bitmap_bit_run_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [14:0] i_bit_offset,
    input  logic [15:0] i_run_length,
    input  logic [11:0] i_byte_index,
    input  logic [7:0]  i_write_data,
    input  logic        i_write_enable,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [11:0] o_first_byte,
    output logic [12:0] o_bytes_touched,
    output logic [14:0] o_found_offset,
    output logic [15:0] o_found_length,
    output logic [15:0] o_next_start,
    output logic [15:0] o_set_count,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import bbre_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bbre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bbre_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_bit_offset    (i_bit_offset),
        .i_run_length    (i_run_length),
        .i_byte_index    (i_byte_index),
        .i_write_data    (i_write_data),
        .i_write_enable  (i_write_enable),
        .o_status        (o_status),
        .o_first_byte    (o_first_byte),
        .o_bytes_touched (o_bytes_touched),
        .o_found_offset  (o_found_offset),
        .o_found_length  (o_found_length),
        .o_next_start    (o_next_start),
        .o_set_count     (o_set_count),
        .o_read_data     (o_read_data)
    );

endmodule
